// File: sv/idm_pkg.sv
// idm_pkg: shared constants and the per-stage control record of the divider
// no dependencies; imported by every divider module
`default_nettype none

package idm_pkg;

	// port width of every data field, fixed
	localparam int FIELD_W = 64;

	// default operand width handled by the divide array
	localparam int DATA_WIDTH_DEF = 64;

	// control record that travels down the array beside the data
	typedef struct packed {
		logic valid;   // stage holds a live beat
		logic neg_q;   // quotient must be negated at the end
		logic neg_r;   // remainder must be negated at the end
		logic dbz;     // divisor was zero
	} idm_ctl_t;

endpackage

`default_nettype wire

// File: sv/int64_divide_modulo.sv
// int64_divide_modulo: pipelined restoring divider, quotient, remainder, zero flag
// depends on idm_pkg, idm_prep, idm_cell, idm_post
`default_nettype none

//  channel | beat fields                          | handshake
//  --------+--------------------------------------+---------------------
//  in      | dividend, divisor, signed_mode       | in_valid / in_stall
//  out     | quotient, remainder, div_by_zero     | out_valid / out_stall
//
//  one beat enters per cycle while in_stall is low, before earlier ones leave;
//  each passes the operand stage, then the row of DATA_WIDTH divide cells,
//  one quotient bit each, then the sign fixup stage behind
//  the whole array advances together; a stalled result freezes every stage
//  and raises in_stall in the same cycle
//  reset clears only the control records and out_valid; data registers keep garbage

module int64_divide_modulo
	import idm_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// input beats
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [FIELD_W-1:0] dividend,
	input  wire logic [FIELD_W-1:0] divisor,
	input  wire logic               signed_mode,
	// result beats
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [FIELD_W-1:0]      quotient,
	output logic [FIELD_W-1:0]      remainder,
	output logic                    div_by_zero
);

	localparam int W = DATA_WIDTH;

	// global advance: everything moves unless a finished result is held
	logic en;

	// cell row taps: index 0 is the operand stage, index W the last cell
	idm_ctl_t     ctl_c [0:W];
	logic [W-1:0] rem_c [0:W];
	logic [W-1:0] nq_c  [0:W];
	logic [W-1:0] den_c [0:W];

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// operand stage: magnitudes, sign plan, zero check
	idm_prep #(
		.W (W)
	) u_prep (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_take     (in_valid),
		.dividend    (dividend),
		.divisor     (divisor),
		.signed_mode (signed_mode),
		.ctl_s1      (ctl_c[0]),
		.num_s1      (nq_c[0]),
		.den_s1      (den_c[0])
	);

	// partial remainder starts at zero
	assign rem_c[0] = '0;

	// row of divide cells, the dividend walks out as the quotient walks in
	for (genvar k = 0; k < W; k++) begin : g_cell
		idm_cell #(
			.W (W)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_i  (ctl_c[k]),
			.rem_i  (rem_c[k]),
			.nq_i   (nq_c[k]),
			.den_i  (den_c[k]),
			.ctl_q  (ctl_c[k+1]),
			.rem_q  (rem_c[k+1]),
			.nq_q   (nq_c[k+1]),
			.den_q  (den_c[k+1])
		);
	end

	// sign fixup and output register
	idm_post #(
		.W (W)
	) u_post (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.ctl_i       (ctl_c[W]),
		.rem_i       (rem_c[W]),
		.quo_i       (nq_c[W]),
		.out_valid   (out_valid),
		.quotient    (quotient),
		.remainder   (remainder),
		.div_by_zero (div_by_zero)
	);

endmodule

`default_nettype wire

// File: sv/idm_prep.sv
// idm_prep: operand conditioning, magnitudes of signed operands and zero check
// depends on idm_pkg
`default_nettype none

module idm_prep
	import idm_pkg::*;
#(
	parameter int W = DATA_WIDTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_take,
	input  wire logic [FIELD_W-1:0] dividend,
	input  wire logic [FIELD_W-1:0] divisor,
	input  wire logic               signed_mode,
	output idm_ctl_t                ctl_s1,
	output logic [W-1:0]            num_s1,
	output logic [W-1:0]            den_s1
);

	logic [W-1:0] a;
	logic [W-1:0] b;
	logic         an;
	logic         bn;
	logic [W-1:0] ua;
	logic [W-1:0] ub;
	idm_ctl_t     ctl_d;

	always_comb begin
		a  = dividend[W-1:0];
		b  = divisor[W-1:0];
		an = signed_mode & a[W-1];
		bn = signed_mode & b[W-1];
		ua = an ? (W'(0) - a) : a;
		ub = bn ? (W'(0) - b) : b;
		ctl_d.valid = in_take;
		ctl_d.neg_q = an ^ bn;
		ctl_d.neg_r = an;
		ctl_d.dbz   = (b == W'(0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1 <= ua;
			den_s1 <= ub;
		end
	end

endmodule

`default_nettype wire

// File: sv/idm_cell.sv
// idm_cell: one restoring step, settles one quotient bit per stage
// depends on idm_pkg
`default_nettype none

module idm_cell
	import idm_pkg::*;
#(
	parameter int W = DATA_WIDTH_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire idm_ctl_t     ctl_i,
	input  wire logic [W-1:0] rem_i,
	input  wire logic [W-1:0] nq_i,
	input  wire logic [W-1:0] den_i,
	output idm_ctl_t          ctl_q,
	output logic [W-1:0]      rem_q,
	output logic [W-1:0]      nq_q,
	output logic [W-1:0]      den_q
);

	logic [W:0]   trial;
	logic [W:0]   diff;
	logic         take;

	// partial remainder keeps its carry bit in trial[W]
	always_comb begin
		trial = {rem_i, nq_i[W-1]};
		diff  = trial - {1'b0, den_i};
		take  = !diff[W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_i;
		end
	end

	// dividend bits shift out at the top, quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= take ? diff[W-1:0] : trial[W-1:0];
			nq_q  <= {nq_i[W-2:0], take};
			den_q <= den_i;
		end
	end

endmodule

`default_nettype wire

// File: sv/idm_post.sv
// idm_post: sign fixup, zero-divisor override and the output register
// depends on idm_pkg
`default_nettype none

module idm_post
	import idm_pkg::*;
#(
	parameter int W = DATA_WIDTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire idm_ctl_t           ctl_i,
	input  wire logic [W-1:0]       rem_i,
	input  wire logic [W-1:0]       quo_i,
	output logic                    out_valid,
	output logic [FIELD_W-1:0]      quotient,
	output logic [FIELD_W-1:0]      remainder,
	output logic                    div_by_zero
);

	logic [W-1:0] q_fix;
	logic [W-1:0] r_fix;

	always_comb begin
		if (ctl_i.dbz) begin
			q_fix = '0;
		end else if (ctl_i.neg_q) begin
			q_fix = W'(0) - quo_i;
		end else begin
			q_fix = quo_i;
		end
		// zero divisor leaves the magnitude of the dividend here, so this restores it
		r_fix = ctl_i.neg_r ? (W'(0) - rem_i) : rem_i;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= ctl_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quotient    <= FIELD_W'(q_fix);
			remainder   <= FIELD_W'(r_fix);
			div_by_zero <= ctl_i.dbz;
		end
	end

endmodule

`default_nettype wire

// File: sv/idm_checker.sv
// idm_checker: port-level checks on the divider, bound to the top level
// depends on idm_pkg and int64_divide_modulo
`default_nettype none

module idm_checker
	import idm_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic [FIELD_W-1:0] quotient,
	input wire logic [FIELD_W-1:0] remainder,
	input wire logic               div_by_zero
);

	// input side is held exactly while a result is held
	a_stall_link: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("in_stall does not follow the held result");

	// a zero divisor always reports a zero quotient
	a_dbz_quot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && div_by_zero) |-> (quotient == '0))
		else $error("zero divisor gave a nonzero quotient");

	// held result beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(quotient)
			&& $stable(remainder) && $stable(div_by_zero)))
		else $error("held result beat changed");

	// in_stall is never seen raised with no result beat held and no input beat offered
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid && !$past(out_valid) && !$past(in_valid)) |-> !$past(in_stall))
		else $error("stall raised with no result held");

endmodule

bind int64_divide_modulo idm_checker u_idm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.quotient    (quotient),
	.remainder   (remainder),
	.div_by_zero (div_by_zero)
);

`default_nettype wire

// File: tb/int64_divide_modulo_tb.sv
`timescale 1ns / 100ps
// int64_divide_modulo_tb: self-checking bench for the pipelined 64-bit divider
// depends on idm_pkg and int64_divide_modulo; predicts every result beat and
// checks it field by field under random idling, stalls and a long hold-off

module int64_divide_modulo_tb;
	import idm_pkg::*;

	// operand corner values
	localparam logic [FIELD_W-1:0] OP_ZERO = '0;
	localparam logic [FIELD_W-1:0] OP_ONE  = 64'd1;
	localparam logic [FIELD_W-1:0] OP_ONES = '1;
	localparam logic [FIELD_W-1:0] OP_MIN  = 64'h8000_0000_0000_0000;
	localparam logic [FIELD_W-1:0] OP_MAX  = 64'h7fff_ffff_ffff_ffff;

	// mode codes for signed_mode
	localparam logic MODE_UNSIGNED = 1'b0;
	localparam logic MODE_SIGNED   = 1'b1;

	localparam int RANDOM_PER_PHASE = 500;
	localparam int LONG_HOLD        = 300;    // receiver hold-off, in cycles
	localparam int TAIL_CYCLES      = DATA_WIDTH_DEF + 8;
	localparam int LIMIT_NS         = 1_000_000;
	localparam int REPORT_MAX       = 10;

	typedef struct {
		logic [FIELD_W-1:0] dividend;
		logic [FIELD_W-1:0] divisor;
		logic               signed_mode;
	} div_beat_t;

	typedef struct {
		logic [FIELD_W-1:0] quotient;
		logic [FIELD_W-1:0] remainder;
		logic               div_by_zero;
	} div_result_t;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               in_valid    = 1'b0;
	logic               in_stall;
	logic [FIELD_W-1:0] dividend    = '0;
	logic [FIELD_W-1:0] divisor     = '0;
	logic               signed_mode = MODE_UNSIGNED;
	logic               out_valid;
	logic               out_stall   = 1'b0;
	logic [FIELD_W-1:0] quotient;
	logic [FIELD_W-1:0] remainder;
	logic               div_by_zero;

	div_beat_t   pending_div_q[$];   // operand beats not yet accepted
	div_result_t expected_div_q[$];  // predicted results, oldest first
	div_result_t want;

	logic in_taken    = 1'b0;  // an operand beat was accepted at the last rising edge
	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	logic hold_req    = 1'b0;  // asks the receiver for one long hold-off
	int   hold_left   = 0;
	int   err_count   = 0;

	int64_divide_modulo dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.dividend    (dividend),
		.divisor     (divisor),
		.signed_mode (signed_mode),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.quotient    (quotient),
		.remainder   (remainder),
		.div_by_zero (div_by_zero)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// truncating division: magnitudes are divided, then the sign is applied;
	// the remainder is whatever is left of the dividend, wrapped to 64 bits
	function automatic div_result_t divide_predict(logic [FIELD_W-1:0] num,
			logic [FIELD_W-1:0] den, logic sgn);
		div_result_t        res;
		logic               neg_num;
		logic               neg_den;
		logic [FIELD_W-1:0] mag_num;
		logic [FIELD_W-1:0] mag_den;
		logic [FIELD_W-1:0] quo;
		if (den == OP_ZERO) begin
			res.quotient    = OP_ZERO;
			res.remainder   = num;
			res.div_by_zero = 1'b1;
			return res;
		end
		neg_num = (sgn == MODE_SIGNED) && num[FIELD_W-1];
		neg_den = (sgn == MODE_SIGNED) && den[FIELD_W-1];
		mag_num = neg_num ? -num : num;
		mag_den = neg_den ? -den : den;
		quo = mag_num / mag_den;
		// most negative over minus one wraps back to the most negative value here
		if (neg_num != neg_den) quo = -quo;
		res.quotient    = quo;
		res.remainder   = num - quo * den;
		res.div_by_zero = 1'b0;
		return res;
	endfunction

	// operand shapes: full random, tiny, shifted down, small negative, corners
	function automatic logic [FIELD_W-1:0] pick_operand();
		logic [FIELD_W-1:0] v;
		v = {$urandom(), $urandom()};
		case ($urandom_range(7))
			0: begin
				v = 64'($urandom_range(15));
			end
			1: begin
				v = v >> $urandom_range(FIELD_W - 1);
			end
			2: begin
				v = -(64'($urandom_range(15)));
			end
			3: begin
				case ($urandom_range(4))
					0: v = OP_ZERO;
					1: v = OP_ONE;
					2: v = OP_ONES;
					3: v = OP_MIN;
					default: v = OP_MAX;
				endcase
			end
			4: begin
				v = v >> $urandom_range(FIELD_W / 2, FIELD_W - 1);
			end
			default: begin
			end
		endcase
		return v;
	endfunction

	task automatic queue_division(logic [FIELD_W-1:0] num, logic [FIELD_W-1:0] den,
			logic sgn);
		div_beat_t b;
		b.dividend    = num;
		b.divisor     = den;
		b.signed_mode = sgn;
		pending_div_q.push_back(b);
	endtask

	task automatic queue_random(int n);
		repeat (n) queue_division(pick_operand(), pick_operand(), logic'($urandom_range(1)));
	endtask

	// sender pause: nothing left to send and every result back
	task automatic wait_drained();
		while (pending_div_q.size() != 0 || expected_div_q.size() != 0) @(posedge clk);
	endtask

	task automatic report_mismatch(string what, logic [FIELD_W-1:0] exp_v,
			logic [FIELD_W-1:0] act_v);
		err_count++;
		if (err_count <= REPORT_MAX)
			$display("%0t ns: %s mismatch, expected %h, got %h", $time, what, exp_v, act_v);
	endtask

	// driver: presents the head of the pending queue, holds it until taken
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_taken) void'(pending_div_q.pop_front());
			if (in_valid && !in_taken) begin
				// beat still waiting on in_stall, keep it steady
			end else if (pending_div_q.size() == 0) begin
				in_valid <= 1'b0;
			end else if ($urandom_range(99) < send_idle_pct) begin
				in_valid <= 1'b0;
			end else begin
				in_valid    <= 1'b1;
				dividend    <= pending_div_q[0].dividend;
				divisor     <= pending_div_q[0].divisor;
				signed_mode <= pending_div_q[0].signed_mode;
			end
		end
	end

	// receiver: random stalls, or a long hold-off counted down here
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
		end else if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req) begin
			out_stall <= 1'b1;
			hold_left <= LONG_HOLD;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// monitor: checks result beats, then predicts for any accepted operand beat
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_div_q.size() == 0) begin
				err_count++;
				if (err_count <= REPORT_MAX)
					$display("%0t ns: result beat with nothing expected, q %h r %h z %b",
						$time, quotient, remainder, div_by_zero);
			end else begin
				want = expected_div_q.pop_front();
				if (quotient !== want.quotient)
					report_mismatch("quotient", want.quotient, quotient);
				if (remainder !== want.remainder)
					report_mismatch("remainder", want.remainder, remainder);
				if (div_by_zero !== want.div_by_zero)
					report_mismatch("div_by_zero", 64'(want.div_by_zero), 64'(div_by_zero));
			end
		end
		if (arst_n && in_valid && !in_stall)
			expected_div_q.push_back(divide_predict(dividend, divisor, signed_mode));
		in_taken <= arst_n && in_valid && !in_stall;
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners, no idling
		queue_division(OP_MAX, OP_ZERO, MODE_UNSIGNED);   // zero divisor
		queue_division(OP_MIN, OP_ZERO, MODE_SIGNED);     // zero divisor, negative dividend
		queue_division(OP_ZERO, OP_ZERO, MODE_SIGNED);
		queue_division(OP_MIN, OP_ONES, MODE_SIGNED);     // most negative over minus one
		queue_division(OP_MIN, OP_ONES, MODE_UNSIGNED);
		queue_division(OP_MIN, OP_ONE, MODE_SIGNED);
		queue_division(OP_MIN, OP_MIN, MODE_SIGNED);
		queue_division(OP_ONES, OP_ONES, MODE_SIGNED);
		queue_division(OP_ONES, OP_ONE, MODE_UNSIGNED);
		queue_division(OP_ONES, OP_ONES, MODE_UNSIGNED);
		queue_division(OP_ONE, OP_ONES, MODE_UNSIGNED);
		queue_division(OP_ZERO, OP_MAX, MODE_SIGNED);
		queue_division(OP_MAX, OP_MIN, MODE_SIGNED);
		queue_division(OP_ONES, OP_MIN, MODE_UNSIGNED);   // divisor top bit set
		queue_division(64'hffff_ffff_ffff_fffe, 64'h8000_0000_0000_0001, MODE_UNSIGNED);
		queue_division(-64'd7, 64'd2, MODE_SIGNED);       // negative by positive
		queue_division(64'd7, -64'd2, MODE_SIGNED);       // positive by negative
		queue_division(-64'd7, -64'd2, MODE_SIGNED);
		queue_division(-64'd7, 64'd2, MODE_UNSIGNED);
		queue_division(64'd7, 64'd2, MODE_SIGNED);
		queue_division(OP_MAX, 64'd3, MODE_SIGNED);
		queue_division(64'h1234_5678_9abc_def0, 64'h0000_0001_0000_0000, MODE_UNSIGNED);
		wait_drained();

		// full rate with one long receiver hold-off so the array backs up
		hold_req = 1'b1;
		queue_random(RANDOM_PER_PHASE);
		while (hold_left == 0) @(posedge clk);
		hold_req = 1'b0;
		wait_drained();

		// sender idling
		send_idle_pct = 57;
		queue_random(RANDOM_PER_PHASE);
		wait_drained();

		// receiver stalling
		send_idle_pct  = 0;
		recv_stall_pct = 57;
		queue_random(RANDOM_PER_PHASE);
		wait_drained();

		// light idling on both sides
		send_idle_pct  = 9;
		recv_stall_pct = 9;
		queue_random(RANDOM_PER_PHASE);
		wait_drained();

		// let any stray beat fall out of the array
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0) begin
			$display("int64_divide_modulo_tb: clean");
		end else begin
			$display("int64_divide_modulo_tb: errors");
		end
		$finish;
	end

	// watchdog
	initial begin
		#(LIMIT_NS);
		$display("int64_divide_modulo_tb: errors");
		$finish;
	end

endmodule

// File: filelist.f
sv/idm_pkg.sv
sv/idm_prep.sv
sv/idm_cell.sv
sv/idm_post.sv
sv/int64_divide_modulo.sv
sv/idm_checker.sv
tb/int64_divide_modulo_tb.sv
